// ===== hw/rtl/frbm_pkg.sv =====
// Shared types and constants for the flow byte rate meter.
package frbm_pkg;

	localparam int FLOW_ENTRIES_DEF = 64;

	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 16;
	localparam int PROTO_W = 8;
	localparam int LEN_W   = 16;
	localparam int BYTE_W  = 64;
	localparam int SHORT_W = 63;
	localparam int MID_W   = 61;
	localparam int LONG_W  = 59;
	localparam int PHASE_W = 5;

	localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
	localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

	// Tick phase runs modulo 20; mid window every 5th tick
	localparam logic [PHASE_W-1:0] PHASE_LAST = 5'd19;
	localparam logic [PHASE_W-1:0] PHASE_M5   = 5'd5;
	localparam logic [PHASE_W-1:0] PHASE_M10  = 5'd10;
	localparam logic [PHASE_W-1:0] PHASE_M15  = 5'd15;

	localparam int MID_DIV  = 10;
	localparam int LONG_DIV = 40;

	// One flow table entry
	typedef struct packed {
		logic [ADDR_W-1:0]  src_addr;
		logic [ADDR_W-1:0]  dst_addr;
		logic [PORT_W-1:0]  sport;
		logic [PORT_W-1:0]  dport;
		logic [BYTE_W-1:0]  cnt;
		logic [BYTE_W-1:0]  at_last;
		logic [BYTE_W-1:0]  at_mid;
		logic [BYTE_W-1:0]  at_long;
		logic [SHORT_W-1:0] peak;
		logic [MID_W-1:0]   hmid;
		logic [LONG_W-1:0]  hlong;
	} entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;
		logic rd;
		logic idx_inc;
		logic wr_hit;
		logic wr_new;
		logic phase_adv;
		logic tload;
		logic wr_tick;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_tick;
		logic cnt_zero;
		logic match;
		logic idx_last;
		logic full;
		logic div_busy;
		logic mid;
	} stat_t;

endpackage

// ===== hw/rtl/flow_byte_rate_meter.sv =====
// Per-flow byte and rate meter, top level.
// Packet: table entries are read and compared one at a time until one matches; a hit adds the
// length to that entry, a miss creates a new entry unless the table is full.
// Tick: each flow is read, updated, written back and sent as a record; every 5th tick also waits for
// the window divides. busy drops in the cycle that carries the last record; records cannot stall.
// Reset clears flow count and tick phase; table entries are written as flows are created.
module flow_byte_rate_meter #(
	parameter int FLOW_ENTRIES = frbm_pkg::FLOW_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         mode,
	input  logic [frbm_pkg::ADDR_W-1:0]  src_addr,
	input  logic [frbm_pkg::ADDR_W-1:0]  dst_addr,
	input  logic [frbm_pkg::PROTO_W-1:0] protocol,
	input  logic [frbm_pkg::PORT_W-1:0]  src_port_raw,
	input  logic [frbm_pkg::PORT_W-1:0]  dst_port_raw,
	input  logic [frbm_pkg::LEN_W-1:0]   pkt_len,
	output logic                         rec_valid,
	output logic [frbm_pkg::ADDR_W-1:0]  rec_src_addr,
	output logic [frbm_pkg::ADDR_W-1:0]  rec_dst_addr,
	output logic [frbm_pkg::PORT_W-1:0]  rec_src_port,
	output logic [frbm_pkg::PORT_W-1:0]  rec_dst_port,
	output logic [frbm_pkg::BYTE_W-1:0]  byte_total,
	output logic [frbm_pkg::SHORT_W-1:0] rate_short,
	output logic [frbm_pkg::MID_W-1:0]   rate_mid,
	output logic [frbm_pkg::LONG_W-1:0]  rate_long,
	output logic [frbm_pkg::SHORT_W-1:0] rate_peak,
	output logic                         last
);

	frbm_pkg::cmd_t  cmd;
	frbm_pkg::stat_t stat;

	frbm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	frbm_dp #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.src_addr    (src_addr),
		.dst_addr    (dst_addr),
		.protocol    (protocol),
		.src_port_raw(src_port_raw),
		.dst_port_raw(dst_port_raw),
		.pkt_len     (pkt_len),
		.rec_valid   (rec_valid),
		.rec_src_addr(rec_src_addr),
		.rec_dst_addr(rec_dst_addr),
		.rec_src_port(rec_src_port),
		.rec_dst_port(rec_dst_port),
		.byte_total  (byte_total),
		.rate_short  (rate_short),
		.rate_mid    (rate_mid),
		.rate_long   (rate_long),
		.rate_peak   (rate_peak),
		.last        (last)
	);

endmodule

// ===== hw/rtl/frbm_ram.sv =====
// Generic single write, single read RAM with registered read data.
module frbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/frbm_div.sv =====
// Divider by a constant of the form 5 * 2^k, by reciprocal multiplication in 32 x 32 partial products.
module frbm_div #(
	parameter int DIVISOR = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [frbm_pkg::BYTE_W-1:0] dividend,
	output logic [frbm_pkg::BYTE_W-1:0] quot,
	output logic                       busy
);

	localparam int HALF_W = frbm_pkg::BYTE_W / 2;
	localparam int ACC_W  = 2 * frbm_pkg::BYTE_W;
	localparam int PRE_SH = $clog2(DIVISOR / 5);
	localparam int Q_SH   = 66;
	// ceil(2^66 / 5): exact floor(x / 5) for any 64-bit x after a shift by 66
	localparam logic [frbm_pkg::BYTE_W-1:0] RECIP_5 = 64'hCCCC_CCCC_CCCC_CCCD;
	localparam logic [2:0] STEP_END = 3'd4;

	logic [frbm_pkg::BYTE_W-1:0] num_q;
	logic [2:0]                  step_q;
	logic                        busy_q;
	logic [frbm_pkg::BYTE_W-1:0] prod_q;
	logic [1:0]                  wt_q;
	logic [ACC_W-1:0]            acc_q;
	logic [HALF_W-1:0]           op_a, op_b;
	logic [frbm_pkg::BYTE_W-1:0] pp;
	logic [1:0]                  wt;
	logic [ACC_W-1:0]            addend;

	// One 32 x 32 partial product per step; its weight is 2^(32 * wt)
	assign op_a   = step_q[1] ? num_q[frbm_pkg::BYTE_W-1:HALF_W] : num_q[HALF_W-1:0];
	assign op_b   = step_q[0] ? RECIP_5[frbm_pkg::BYTE_W-1:HALF_W] : RECIP_5[HALF_W-1:0];
	assign pp     = op_a * op_b;
	assign wt     = {1'b0, step_q[1]} + {1'b0, step_q[0]};
	assign addend = {{frbm_pkg::BYTE_W{1'b0}}, prod_q} << {wt_q, 5'b00000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_END) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Products are registered, then summed in the next step
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend >> PRE_SH;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q != STEP_END) begin
				prod_q <= pp;
				wt_q   <= wt;
			end
			if (step_q != '0) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	assign quot = frbm_pkg::BYTE_W'(acc_q[ACC_W-1:Q_SH]);
	assign busy = busy_q;

endmodule

// ===== hw/rtl/frbm_dp.sv =====
// Datapath: input capture, flow table, rate arithmetic and record registers.
module frbm_dp #(
	parameter int FLOW_ENTRIES = frbm_pkg::FLOW_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  frbm_pkg::cmd_t               cmd,
	output frbm_pkg::stat_t              stat,
	input  logic                         mode,
	input  logic [frbm_pkg::ADDR_W-1:0]  src_addr,
	input  logic [frbm_pkg::ADDR_W-1:0]  dst_addr,
	input  logic [frbm_pkg::PROTO_W-1:0] protocol,
	input  logic [frbm_pkg::PORT_W-1:0]  src_port_raw,
	input  logic [frbm_pkg::PORT_W-1:0]  dst_port_raw,
	input  logic [frbm_pkg::LEN_W-1:0]   pkt_len,
	output logic                         rec_valid,
	output logic [frbm_pkg::ADDR_W-1:0]  rec_src_addr,
	output logic [frbm_pkg::ADDR_W-1:0]  rec_dst_addr,
	output logic [frbm_pkg::PORT_W-1:0]  rec_src_port,
	output logic [frbm_pkg::PORT_W-1:0]  rec_dst_port,
	output logic [frbm_pkg::BYTE_W-1:0]  byte_total,
	output logic [frbm_pkg::SHORT_W-1:0] rate_short,
	output logic [frbm_pkg::MID_W-1:0]   rate_mid,
	output logic [frbm_pkg::LONG_W-1:0]  rate_long,
	output logic [frbm_pkg::SHORT_W-1:0] rate_peak,
	output logic                         last
);

	localparam int IDX_W = FLOW_ENTRIES > 1 ? $clog2(FLOW_ENTRIES) : 1;
	localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(FLOW_ENTRIES);

	logic                         mode_q;
	logic [frbm_pkg::ADDR_W-1:0]  sa_q, da_q;
	logic [frbm_pkg::PORT_W-1:0]  sp_q, dp_q;
	logic [frbm_pkg::LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]             idx_q;
	logic [CNT_W-1:0]             count_q;
	logic [frbm_pkg::PHASE_W-1:0] phase_q, phase_nx;
	logic                         mid_q, lng_q;
	frbm_pkg::entry_t             rd_ent, ent_q, wr_ent, tick_ent;
	logic [frbm_pkg::SHORT_W-1:0] r2_q;
	logic [frbm_pkg::BYTE_W-1:0]  diff_last;
	logic [frbm_pkg::BYTE_W-1:0]  q10, q40;
	logic                         busy10, busy40;
	logic                         we, tp;
	logic [IDX_W-1:0]             waddr;
	logic                         rec_valid_q;

	// Ports only for TCP or UDP
	assign tp = (protocol == frbm_pkg::PROTO_TCP) || (protocol == frbm_pkg::PROTO_UDP);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			sa_q   <= src_addr;
			da_q   <= dst_addr;
			sp_q   <= tp ? src_port_raw : '0;
			dp_q   <= tp ? dst_port_raw : '0;
			len_q  <= pkt_len;
		end
	end

	// Table index, flow count and tick phase
	assign phase_nx = (phase_q == frbm_pkg::PHASE_LAST) ? '0 : phase_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			phase_q <= '0;
			mid_q   <= 1'b0;
			lng_q   <= 1'b0;
		end else begin
			if (cmd.latch) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.wr_new) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.phase_adv) begin
				phase_q <= phase_nx;
				mid_q   <= (phase_nx == '0) || (phase_nx == frbm_pkg::PHASE_M5) ||
					(phase_nx == frbm_pkg::PHASE_M10) || (phase_nx == frbm_pkg::PHASE_M15);
				lng_q   <= (phase_nx == '0);
			end
		end
	end

	// Flow table
	assign we    = cmd.wr_hit | cmd.wr_new | cmd.wr_tick;
	assign waddr = cmd.wr_new ? count_q[IDX_W-1:0] : idx_q;

	frbm_ram #(
		.WIDTH($bits(frbm_pkg::entry_t)),
		.DEPTH(FLOW_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_ent),
		.re   (cmd.rd),
		.raddr(idx_q),
		.rdata(rd_ent)
	);

	// Window dividers
	frbm_div #(.DIVISOR(frbm_pkg::MID_DIV)) u_div_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.tload & mid_q),
		.dividend(rd_ent.cnt - rd_ent.at_mid),
		.quot    (q10),
		.busy    (busy10)
	);

	frbm_div #(.DIVISOR(frbm_pkg::LONG_DIV)) u_div_long (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.tload & lng_q),
		.dividend(rd_ent.cnt - rd_ent.at_long),
		.quot    (q40),
		.busy    (busy40)
	);

	// Capture entry and 2 s rate for a tick
	assign diff_last = rd_ent.cnt - rd_ent.at_last;

	always_ff @(posedge clk) begin
		if (cmd.tload) begin
			ent_q <= rd_ent;
			r2_q  <= diff_last[frbm_pkg::BYTE_W-1:1];
		end
	end

	// Updated entry after a tick
	always_comb begin
		tick_ent         = ent_q;
		tick_ent.at_last = ent_q.cnt;
		tick_ent.peak    = (r2_q > ent_q.peak) ? r2_q : ent_q.peak;
		if (mid_q) begin
			tick_ent.hmid   = q10[frbm_pkg::MID_W-1:0];
			tick_ent.at_mid = ent_q.cnt;
		end
		if (lng_q) begin
			tick_ent.hlong   = q40[frbm_pkg::LONG_W-1:0];
			tick_ent.at_long = ent_q.cnt;
		end
	end

	// Write word select
	always_comb begin
		wr_ent = tick_ent;
		if (cmd.wr_hit) begin
			wr_ent     = rd_ent;
			wr_ent.cnt = rd_ent.cnt + frbm_pkg::BYTE_W'(len_q);
		end else if (cmd.wr_new) begin
			wr_ent          = '0;
			wr_ent.src_addr = sa_q;
			wr_ent.dst_addr = da_q;
			wr_ent.sport    = sp_q;
			wr_ent.dport    = dp_q;
			wr_ent.cnt      = frbm_pkg::BYTE_W'(len_q);
		end
	end

	// Record word registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else begin
			rec_valid_q <= cmd.wr_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_tick) begin
			rec_src_addr <= ent_q.src_addr;
			rec_dst_addr <= ent_q.dst_addr;
			rec_src_port <= ent_q.sport;
			rec_dst_port <= ent_q.dport;
			byte_total   <= ent_q.cnt;
			rate_short   <= r2_q;
			rate_mid     <= tick_ent.hmid;
			rate_long    <= tick_ent.hlong;
			rate_peak    <= tick_ent.peak;
			last         <= stat.idx_last;
		end
	end

	assign rec_valid = rec_valid_q;

	// Status
	assign stat.is_tick  = mode_q;
	assign stat.cnt_zero = (count_q == '0);
	assign stat.match    = (rd_ent.src_addr == sa_q) && (rd_ent.dst_addr == da_q) &&
		(rd_ent.sport == sp_q) && (rd_ent.dport == dp_q);
	assign stat.idx_last = ((CNT_W'(idx_q) + 1'b1) == count_q);
	assign stat.full     = (count_q == FULL_C);
	assign stat.div_busy = busy10 | busy40;
	assign stat.mid      = mid_q;

endmodule

// ===== hw/rtl/frbm_ctrl.sv =====
// Controller state machine sequencing lookups and tick walks.
module frbm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  frbm_pkg::stat_t   stat,
	output frbm_pkg::cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DISP   = 4'd1;
	localparam logic [3:0] ST_P_CMP  = 4'd2;
	localparam logic [3:0] ST_P_RD   = 4'd3;
	localparam logic [3:0] ST_P_NEW  = 4'd4;
	localparam logic [3:0] ST_T_LOAD = 4'd5;
	localparam logic [3:0] ST_T_DIV  = 4'd6;
	localparam logic [3:0] ST_T_WR   = 4'd7;
	localparam logic [3:0] ST_T_RD   = 4'd8;

	logic [3:0] state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_nx  = ST_DISP;
				end
			end
			ST_DISP: begin
				if (stat.is_tick) begin
					cmd.phase_adv = 1'b1;
					if (stat.cnt_zero) begin
						state_nx = ST_IDLE;
					end else begin
						cmd.rd   = 1'b1;
						state_nx = ST_T_LOAD;
					end
				end else if (stat.cnt_zero) begin
					state_nx = ST_P_NEW;
				end else begin
					cmd.rd   = 1'b1;
					state_nx = ST_P_CMP;
				end
			end
			ST_P_CMP: begin
				if (stat.match) begin
					cmd.wr_hit = 1'b1;
					state_nx   = ST_IDLE;
				end else if (stat.idx_last) begin
					state_nx = ST_P_NEW;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = ST_P_RD;
				end
			end
			ST_P_RD: begin
				cmd.rd   = 1'b1;
				state_nx = ST_P_CMP;
			end
			ST_P_NEW: begin
				cmd.wr_new = !stat.full;
				state_nx   = ST_IDLE;
			end
			ST_T_LOAD: begin
				cmd.tload = 1'b1;
				state_nx  = stat.mid ? ST_T_DIV : ST_T_WR;
			end
			ST_T_DIV: begin
				if (!stat.div_busy) begin
					state_nx = ST_T_WR;
				end
			end
			ST_T_WR: begin
				cmd.wr_tick = 1'b1;
				if (stat.idx_last) begin
					state_nx = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = ST_T_RD;
				end
			end
			ST_T_RD: begin
				cmd.rd   = 1'b1;
				state_nx = ST_T_LOAD;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
